// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the block.
// Plain text macros; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, ignored while reset is low
`define LRN_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define LRN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/lrn_pkg.sv =====
// Shared types and constants of the cross-channel LRN block.
// No dependencies.
package lrn_pkg;

  localparam int HW_W      = 3;
  localparam int ALPHA_W   = 32;
  localparam int K_W       = 24;
  localparam int BETA_W    = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 36;
  localparam int SQ_W      = 32;
  localparam int D_W       = 54;
  localparam int FRAC_BITS = 24;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K_OFFSET      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA_EXPONENT = 2'd3;

  localparam logic [HW_W-1:0]    HALF_WINDOW_RST   = 3'd2;
  localparam logic [ALPHA_W-1:0] ALPHA_SCALE_RST   = 32'd429497;
  localparam logic [K_W-1:0]     K_OFFSET_RST      = 24'd131072;
  localparam logic [BETA_W-1:0]  BETA_EXPONENT_RST = 16'd12288;

  typedef struct packed {
    logic [HW_W-1:0]    half_window;
    logic [ALPHA_W-1:0] alpha_scale;
    logic [K_W-1:0]     k_offset;
    logic [BETA_W-1:0]  beta_exponent;
  } cfg_t;

endpackage

// ===== hdl/lrn_cross_channel_forward_top.sv =====
// Top level of the cross-channel LRN block: config registers, front end,
// job queue and back end. Uses lrn_pkg, lrn_front, lrn_queue, lrn_back.
//
// Usage: feed one pixel's channels in order on in_* (valid/ready), the final
// channel with in_last_channel set. Results leave on out_* in channel order,
// out_last_of_vector on the pixel's final channel. Registers are to be
// written on cfg_* (cfg_we, cfg_index, cfg_data) only while the block is
// idle; the block itself does not enforce this.
// Front: each result of an accepted beat sums up to (window size) elements
// of the square line in sequence, one element a cycle, before its job is
// queued. A last-channel beat issues up to h+1 jobs before the next beat is
// taken. Back: per result it forms the denominator, shifts it to the leading
// one (one bit a cycle) and runs 24 log squarings, then up to 24 square roots
// on the shared bit-serial square root unit; with zero beta these steps are
// skipped and the sample goes to the output register as it is.
// A 4-deep job queue lets front and back stall independently; the output
// register holds a result while out_ready is low and the back end waits.
// Synchronous reset (rst_n low) empties all lines and the queue and loads
// the register defaults.
module lrn_cross_channel_forward_top import lrn_pkg::*; #(
  parameter int HALF_MAX     = 7,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last_channel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_normalized,
  output logic                           out_last_of_vector,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data
);

  localparam int JOB_W = SAMPLE_WIDTH + SUM_W + 1;

  cfg_t cfg_r;

  logic                           job_push, job_full, job_pop, job_empty;
  logic signed [SAMPLE_WIDTH-1:0] push_sample;
  logic [SUM_W-1:0]               push_sum;
  logic                           push_last;
  logic [JOB_W-1:0]               q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_window   <= HALF_WINDOW_RST;
      cfg_r.alpha_scale   <= ALPHA_SCALE_RST;
      cfg_r.k_offset      <= K_OFFSET_RST;
      cfg_r.beta_exponent <= BETA_EXPONENT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_WINDOW:   cfg_r.half_window   <= cfg_data[HW_W-1:0];
        REG_ALPHA_SCALE:   cfg_r.alpha_scale   <= cfg_data[ALPHA_W-1:0];
        REG_K_OFFSET:      cfg_r.k_offset      <= cfg_data[K_W-1:0];
        REG_BETA_EXPONENT: cfg_r.beta_exponent <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  lrn_front #(
    .HALF_MAX     (HALF_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .half_window     (cfg_r.half_window),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .in_last_channel (in_last_channel),
    .job_push        (job_push),
    .job_sample      (push_sample),
    .job_sum         (push_sum),
    .job_last        (push_last),
    .job_full        (job_full)
  );

  assign q_wdata = {push_sample, push_sum, push_last};

  lrn_queue #(
    .DW (JOB_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (q_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (q_rdata),
    .empty (job_empty)
  );

  lrn_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .job_empty          (job_empty),
    .job_pop            (job_pop),
    .job_sample         (q_rdata[JOB_W-1:SUM_W+1]),
    .job_sum            (q_rdata[SUM_W:1]),
    .job_last           (q_rdata[0]),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_normalized     (out_normalized),
    .out_last_of_vector (out_last_of_vector)
  );

endmodule

// ===== hdl/lrn_front.sv =====
// Front end: accepts channel beats, keeps the square and sample lines,
// and issues one job (sample, window sum, last flag) per result. Uses lrn_pkg.
module lrn_front import lrn_pkg::*; #(
  parameter int HALF_MAX     = 7,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [HW_W-1:0]                half_window,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last_channel,
  output logic                           job_push,
  output logic signed [SAMPLE_WIDTH-1:0] job_sample,
  output logic [SUM_W-1:0]               job_sum,
  output logic                           job_last,
  input  logic                           job_full
);

  localparam int SQ_DEPTH  = 2 * HALF_MAX + 1;
  localparam int SMP_DEPTH = HALF_MAX + 1;
  localparam int CNT_MAX   = 2 * HALF_MAX + 1;
  localparam int QI        = $clog2(SQ_DEPTH);
  localparam int SI        = $clog2(SMP_DEPTH);
  localparam int CW        = $clog2(CNT_MAX + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [SQ_W-1:0]                sq_line_r [SQ_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] smp_line_r [SMP_DEPTH];
  logic [CW-1:0]                  seen_r, seen_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [SI-1:0]                  h_r, h_nxt;
  logic [SI-1:0]                  p_r, p_nxt;
  logic [QI-1:0]                  up_r, up_nxt;
  logic [QI-1:0]                  i_r, i_nxt;
  logic [SUM_W-1:0]               acc_r, acc_nxt;
  logic                           flush_r, flush_nxt;

  logic                           accept;
  logic [SAMPLE_WIDTH-1:0]        mag;
  logic [2*SAMPLE_WIDTH-1:0]      sq_full;
  logic [63:0]                    sq64;
  logic [SQ_W-1:0]                sq_sat;
  logic [SUM_W:0]                 acc_add;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign mag     = in_sample[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_sample) : in_sample;
  assign sq_full = mag * mag;
  assign sq64    = 64'(sq_full);
  assign sq_sat  = (|sq64[63:32]) ? '1 : sq64[31:0];

  assign acc_add = {1'b0, acc_r} + (SUM_W + 1)'(sq_line_r[i_r]);

  assign job_push   = (state_r == ST_PUSH) && !job_full;
  assign job_sample = smp_line_r[p_r];
  assign job_sum    = acc_r;
  assign job_last   = flush_r && (p_r == '0);

  always_comb begin
    int h_i, cnt_i, p_i, up_i;
    state_nxt = state_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    h_nxt     = h_r;
    p_nxt     = p_r;
    up_nxt    = up_r;
    i_nxt     = i_r;
    acc_nxt   = acc_r;
    flush_nxt = flush_r;
    h_i   = (int'(half_window) > HALF_MAX) ? HALF_MAX : int'(half_window);
    cnt_i = int'(seen_r) + 1;
    if (cnt_i > CNT_MAX) cnt_i = CNT_MAX;
    p_i   = 0;
    up_i  = 0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = CW'(cnt_i);
          h_nxt   = SI'(h_i);
          i_nxt   = '0;
          acc_nxt = '0;
          if (in_last_channel) begin
            seen_nxt  = '0;
            flush_nxt = 1'b1;
            p_i  = (h_i < cnt_i - 1) ? h_i : cnt_i - 1;
            up_i = (p_i + h_i < cnt_i - 1) ? p_i + h_i : cnt_i - 1;
            p_nxt     = SI'(p_i);
            up_nxt    = QI'(up_i);
            state_nxt = ST_SUM;
          end else begin
            seen_nxt  = CW'(cnt_i);
            flush_nxt = 1'b0;
            if (cnt_i > h_i) begin
              up_i = (2 * h_i < cnt_i - 1) ? 2 * h_i : cnt_i - 1;
              p_nxt     = SI'(h_i);
              up_nxt    = QI'(up_i);
              state_nxt = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        acc_nxt = acc_add[SUM_W] ? '1 : acc_add[SUM_W-1:0];
        if (i_r == up_r) state_nxt = ST_PUSH;
        else             i_nxt = i_r + 1'b1;
      end
      ST_PUSH: begin
        if (!job_full) begin
          if (flush_r && (p_r != '0)) begin
            p_i  = int'(p_r) - 1;
            up_i = (p_i + int'(h_r) < int'(cnt_r) - 1) ? p_i + int'(h_r) : int'(cnt_r) - 1;
            p_nxt     = SI'(p_i);
            up_nxt    = QI'(up_i);
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= '0;
      for (int n = 0; n < SQ_DEPTH; n++) sq_line_r[n] <= '0;
      for (int n = 0; n < SMP_DEPTH; n++) smp_line_r[n] <= '0;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
      if (accept) begin
        sq_line_r[0]  <= sq_sat;
        smp_line_r[0] <= in_sample;
        for (int n = 1; n < SQ_DEPTH; n++) sq_line_r[n] <= sq_line_r[n-1];
        for (int n = 1; n < SMP_DEPTH; n++) smp_line_r[n] <= smp_line_r[n-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    h_r     <= h_nxt;
    p_r     <= p_nxt;
    up_r    <= up_nxt;
    i_r     <= i_nxt;
    acc_r   <= acc_nxt;
    flush_r <= flush_nxt;
  end

endmodule

// ===== hdl/lrn_queue.sv =====
// Short job queue between front and back end, in flip-flops.
// No package dependencies.
module lrn_queue #(
  parameter int DW    = 53,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== hdl/lrn_back.sv =====
// Back end: forms the denominator, takes log2, scales by beta and raises
// 2 to the result with a shared square-root unit; holds the output register. Uses lrn_pkg.
module lrn_back import lrn_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  logic                           job_empty,
  output logic                           job_pop,
  input  logic signed [SAMPLE_WIDTH-1:0] job_sample,
  input  logic [SUM_W-1:0]               job_sum,
  input  logic                           job_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] out_normalized,
  output logic                           out_last_of_vector
);

  localparam int SW = SAMPLE_WIDTH;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_M1    = 4'd1;
  localparam logic [3:0] B_M2    = 4'd2;
  localparam logic [3:0] B_DSUM  = 4'd3;
  localparam logic [3:0] B_DCHK  = 4'd4;
  localparam logic [3:0] B_NORM  = 4'd5;
  localparam logic [3:0] B_SQ    = 4'd6;
  localparam logic [3:0] B_LMUL  = 4'd7;
  localparam logic [3:0] B_SPLIT = 4'd8;
  localparam logic [3:0] B_FSTEP = 4'd9;
  localparam logic [3:0] B_SQRT  = 4'd10;
  localparam logic [3:0] B_PMUL  = 4'd11;
  localparam logic [3:0] B_SCALE = 4'd12;
  localparam logic [3:0] B_OUT   = 4'd13;

  localparam logic [31:0] F_ONE = 32'h4000_0000;

  logic [3:0]           state_r, state_nxt;
  logic signed [SW-1:0] x_r, x_nxt;
  logic [SUM_W-1:0]     s_r, s_nxt;
  logic                 last_r, last_nxt;
  logic [51:0]          prod1_r, prod1_nxt;
  logic [47:0]          prod2_r, prod2_nxt;
  logic [D_W-1:0]       d_r, d_nxt;
  logic [5:0]           z_r, z_nxt;
  logic [31:0]          m_r, m_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [4:0]           i_r, i_nxt;
  logic signed [48:0]   eprod_r, eprod_nxt;
  logic signed [11:0]   ni_r, ni_nxt;
  logic [FRAC_BITS-1:0] nf_r, nf_nxt;
  logic [31:0]          f_r, f_nxt;
  logic [4:0]           j_r, j_nxt;
  logic [63:0]          rad_r, rad_nxt;
  logic [31:0]          root_r, root_nxt;
  logic [35:0]          rem_r, rem_nxt;
  logic [4:0]           k_r, k_nxt;
  logic [63:0]          p_r, p_nxt;
  logic signed [SW-1:0] res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SW-1:0] out_norm_r, out_norm_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 neg;
  logic [SW-1:0]        mag;
  logic signed [SW-1:0] sat_pos, sat_neg;
  logic [63:0]          lim;

  assign neg     = x_r[SW-1];
  assign mag     = neg ? SW'(-x_r) : x_r;
  assign sat_pos = {1'b0, {(SW-1){1'b1}}};
  assign sat_neg = {1'b1, {(SW-1){1'b0}}};
  assign lim     = neg ? (64'd1 << (SW - 1)) : ((64'd1 << (SW - 1)) - 64'd1);

  assign job_pop            = (state_r == B_IDLE) && !job_empty;
  assign out_valid          = out_valid_r;
  assign out_normalized     = out_norm_r;
  assign out_last_of_vector = out_last_r;

  always_comb begin
    logic [63:0]        mm;
    logic [32:0]        t33;
    logic signed [31:0] l_val;
    logic signed [16:0] beta_s;
    logic signed [34:0] e_w;
    logic signed [35:0] n_w;
    logic [35:0]        rem_n, trial;
    logic signed [12:0] s_w, t_w;
    logic [64:0]        rsum;
    logic [63:0]        v;
    state_nxt     = state_r;
    x_nxt         = x_r;
    s_nxt         = s_r;
    last_nxt      = last_r;
    prod1_nxt     = prod1_r;
    prod2_nxt     = prod2_r;
    d_nxt         = d_r;
    z_nxt         = z_r;
    m_nxt         = m_r;
    frac_nxt      = frac_r;
    i_nxt         = i_r;
    eprod_nxt     = eprod_r;
    ni_nxt        = ni_r;
    nf_nxt        = nf_r;
    f_nxt         = f_r;
    j_nxt         = j_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    rem_nxt       = rem_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_norm_nxt  = out_norm_r;
    out_last_nxt  = out_last_r;
    mm     = 64'(m_r) * 64'(m_r);
    t33    = mm[63:31];
    l_val  = $signed({8'(8'd21 - 8'(z_r)), frac_r});
    beta_s = $signed({1'b0, cfg.beta_exponent});
    e_w    = eprod_r[48:14];
    n_w    = 36'sd0 - $signed({e_w[34], e_w});
    rem_n  = {rem_r[33:0], rad_r[63:62]};
    trial  = {2'b00, root_r, 2'b01};
    s_w    = $signed({ni_r[11], ni_r}) - 13'sd30;
    t_w    = 13'sd0 - s_w;
    rsum   = '0;
    v      = '0;
    unique case (state_r)
      B_IDLE: begin
        if (!job_empty) begin
          x_nxt     = job_sample;
          s_nxt     = job_sum;
          last_nxt  = job_last;
          state_nxt = B_M1;
        end
      end
      B_M1: begin
        if (cfg.beta_exponent == '0) begin
          res_nxt   = x_r;
          state_nxt = B_OUT;
        end else begin
          prod1_nxt = 52'(cfg.alpha_scale) * 52'(s_r[SUM_W-1:16]);
          state_nxt = B_M2;
        end
      end
      B_M2: begin
        prod2_nxt = 48'(cfg.alpha_scale) * 48'(s_r[15:0]);
        state_nxt = B_DSUM;
      end
      B_DSUM: begin
        d_nxt     = D_W'({cfg.k_offset, 16'h0000}) + D_W'(prod1_r) + D_W'(prod2_r[47:16]);
        state_nxt = B_DCHK;
      end
      B_DCHK: begin
        if (d_r == '0) begin
          res_nxt   = (x_r == '0) ? '0 : (neg ? sat_neg : sat_pos);
          state_nxt = B_OUT;
        end else begin
          z_nxt     = '0;
          state_nxt = B_NORM;
        end
      end
      B_NORM: begin
        // left-justify d one bit a cycle; z counts leading zeros
        if (d_r[D_W-1]) begin
          m_nxt     = d_r[D_W-1:D_W-32];
          frac_nxt  = '0;
          i_nxt     = '0;
          state_nxt = B_SQ;
        end else begin
          d_nxt = {d_r[D_W-2:0], 1'b0};
          z_nxt = z_r + 1'b1;
        end
      end
      B_SQ: begin
        if (t33[32]) begin
          m_nxt    = t33[32:1];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b1};
        end else begin
          m_nxt    = t33[31:0];
          frac_nxt = {frac_r[FRAC_BITS-2:0], 1'b0};
        end
        if (i_r == 5'(FRAC_BITS - 1)) state_nxt = B_LMUL;
        else                          i_nxt = i_r + 1'b1;
      end
      B_LMUL: begin
        eprod_nxt = beta_s * l_val;
        state_nxt = B_SPLIT;
      end
      B_SPLIT: begin
        ni_nxt    = n_w[35:24];
        nf_nxt    = n_w[23:0];
        f_nxt     = F_ONE;
        j_nxt     = '0;
        state_nxt = B_FSTEP;
      end
      B_FSTEP: begin
        if (j_r == 5'(FRAC_BITS)) begin
          state_nxt = B_PMUL;
        end else if (!nf_r[j_r] && (f_r == F_ONE)) begin
          // sqrt of exactly 1.0 stays 1.0
          j_nxt = j_r + 1'b1;
        end else begin
          t33       = nf_r[j_r] ? {f_r, 1'b0} : {1'b0, f_r};
          rad_nxt   = {1'b0, t33, 30'd0};
          root_nxt  = '0;
          rem_nxt   = '0;
          k_nxt     = '0;
          state_nxt = B_SQRT;
        end
      end
      B_SQRT: begin
        if (rem_n >= trial) begin
          rem_nxt  = rem_n - trial;
          root_nxt = {root_r[30:0], 1'b1};
        end else begin
          rem_nxt  = rem_n;
          root_nxt = {root_r[30:0], 1'b0};
        end
        rad_nxt = {rad_r[61:0], 2'b00};
        if (k_r == 5'd31) begin
          f_nxt     = root_nxt;
          j_nxt     = j_r + 1'b1;
          state_nxt = B_FSTEP;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      B_PMUL: begin
        p_nxt     = 64'(mag) * 64'(f_r);
        state_nxt = B_SCALE;
      end
      B_SCALE: begin
        if (p_r == '0) begin
          v = '0;
        end else if (!s_w[12]) begin
          if (s_w >= 13'sd64)                v = lim;
          else if (p_r > (lim >> s_w[5:0])) v = lim;
          else                               v = p_r << s_w[5:0];
        end else begin
          if (t_w > 13'sd63) begin
            v = '0;
          end else begin
            rsum = {1'b0, p_r} + (65'd1 << (t_w[5:0] - 6'd1));
            v    = 64'(rsum >> t_w[5:0]);
            if (v > lim) v = lim;
          end
        end
        res_nxt   = neg ? SW'(64'd0 - v) : SW'(v);
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_norm_nxt  = res_r;
          out_last_nxt  = last_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    s_r        <= s_nxt;
    last_r     <= last_nxt;
    prod1_r    <= prod1_nxt;
    prod2_r    <= prod2_nxt;
    d_r        <= d_nxt;
    z_r        <= z_nxt;
    m_r        <= m_nxt;
    frac_r     <= frac_nxt;
    i_r        <= i_nxt;
    eprod_r    <= eprod_nxt;
    ni_r       <= ni_nxt;
    nf_r       <= nf_nxt;
    f_r        <= f_nxt;
    j_r        <= j_nxt;
    rad_r      <= rad_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    res_r      <= res_nxt;
    out_norm_r <= out_norm_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hdl/lrn_chk.sv =====
// Port-level checker for the cross-channel LRN block, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module lrn_chk #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last_channel,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [SAMPLE_WIDTH-1:0] out_normalized,
  input logic                           out_last_of_vector
);

  // a stalled result beat holds
  `LRN_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_normalized) && $stable(out_last_of_vector), "result beat changed while stalled")

  // reset leaves the block ready with no result pending
  `LRN_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> in_ready && !out_valid, "bad state after reset")

  // a last-channel beat always flushes, so the front end goes busy
  `LRN_ASSERT(a_flush_busy, clk, rst_n, in_valid && in_ready && in_last_channel |=> !in_ready, "front end took a beat during flush")

endmodule

bind lrn_cross_channel_forward_top lrn_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lrn_chk (.*);
